@@ hdl/csu_pkg.sv @@
// ----------------------------------------------------------------------------
// csu_pkg
// Shared widths, status codes, control word layout and the microcode table
// of the cosine similarity unit.
// ----------------------------------------------------------------------------
package csu_pkg;

    // Accumulator and datapath widths.
    localparam int DOT_W    = 42;
    localparam int NORM_W   = 41;
    localparam int PROD_W   = 2 * NORM_W;       // norm_a * norm_b
    localparam int ROOT_W   = NORM_W;           // floor sqrt of a PROD_W value
    localparam int REM_W    = ROOT_W + 3;       // shared remainder register
    localparam int FRAC_W   = 15;
    localparam int DIVD_W   = DOT_W + FRAC_W;   // |dot| scaled by 2^15
    localparam int MUL_W    = 32;               // element multiplier operand
    localparam int SIM_W    = 16;
    localparam int STATUS_W = 2;
    localparam int ITER_W   = 6;
    localparam int PC_W     = 3;

    localparam int Q_POS_MAX = 32767;
    localparam int Q_NEG_MAX = 32768;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_NORM = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 2'd2;

    // Microprogram addresses.
    localparam logic [PC_W-1:0] STEP_ACC = 3'd0;
    localparam logic [PC_W-1:0] STEP_CHK = 3'd1;
    localparam logic [PC_W-1:0] STEP_MUL = 3'd2;
    localparam logic [PC_W-1:0] STEP_SQI = 3'd3;
    localparam logic [PC_W-1:0] STEP_SQ  = 3'd4;
    localparam logic [PC_W-1:0] STEP_DVI = 3'd5;
    localparam logic [PC_W-1:0] STEP_DV  = 3'd6;
    localparam logic [PC_W-1:0] STEP_OUT = 3'd7;

    typedef enum logic [2:0] {
        OP_ACC,
        OP_CHK,
        OP_MUL,
        OP_SQI,
        OP_SQ,
        OP_DVI,
        OP_DV,
        OP_OUT
    } op_t;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_LAST,
        C_FAIL,
        C_ITER_DONE,
        C_OUT_FREE
    } cond_t;

    typedef struct packed {
        logic              ready;
        op_t               op;
        cond_t             cond;
        logic              hold;
        logic [PC_W-1:0]   target;
        logic              cnt_load;
        logic [ITER_W-1:0] cnt_init;
    } ctrl_t;

    // Datapath conditions seen by the sequencer.
    typedef struct packed {
        logic last_acc;
        logic fail;
        logic out_free;
    } flags_t;

    // Next address is target when the condition holds; otherwise the step
    // repeats when hold is set and falls through when it is clear.
    function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
        ctrl_t w;
        w = '{ready: 1'b0, op: OP_ACC, cond: C_ALWAYS, hold: 1'b0,
              target: STEP_ACC, cnt_load: 1'b0, cnt_init: '0};
        unique case (pc)
            STEP_ACC:
            begin
                w.ready  = 1'b1;
                w.op     = OP_ACC;
                w.cond   = C_LAST;
                w.hold   = 1'b1;
                w.target = STEP_CHK;
            end
            STEP_CHK:
            begin
                w.op       = OP_CHK;
                w.cond     = C_FAIL;
                w.target   = STEP_OUT;
                w.cnt_load = 1'b1;
                w.cnt_init = ITER_W'(NORM_W - 1);
            end
            STEP_MUL:
            begin
                w.op     = OP_MUL;
                w.cond   = C_ITER_DONE;
                w.hold   = 1'b1;
                w.target = STEP_SQI;
            end
            STEP_SQI:
            begin
                w.op       = OP_SQI;
                w.target   = STEP_SQ;
                w.cnt_load = 1'b1;
                w.cnt_init = ITER_W'(ROOT_W - 1);
            end
            STEP_SQ:
            begin
                w.op     = OP_SQ;
                w.cond   = C_ITER_DONE;
                w.hold   = 1'b1;
                w.target = STEP_DVI;
            end
            STEP_DVI:
            begin
                w.op       = OP_DVI;
                w.target   = STEP_DV;
                w.cnt_load = 1'b1;
                w.cnt_init = ITER_W'(DIVD_W - 1);
            end
            STEP_DV:
            begin
                w.op     = OP_DV;
                w.cond   = C_ITER_DONE;
                w.hold   = 1'b1;
                w.target = STEP_OUT;
            end
            STEP_OUT:
            begin
                w.op     = OP_OUT;
                w.cond   = C_OUT_FREE;
                w.hold   = 1'b1;
                w.target = STEP_ACC;
            end
        endcase
        return w;
    endfunction

endpackage

@@ hdl/csu_if.sv @@
// ----------------------------------------------------------------------------
// csu_if
// Valid/ready channels of the cosine similarity unit: element pairs in,
// similarity results out.
// ----------------------------------------------------------------------------
interface csu_pair_if #(
    parameter int ELEM_WIDTH = 16
) ();
    logic                         valid;
    logic                         ready;
    logic signed [ELEM_WIDTH-1:0] elem_a;
    logic signed [ELEM_WIDTH-1:0] elem_b;
    logic                         last;

    modport source (output valid, elem_a, elem_b, last, input ready);
    modport sink   (input valid, elem_a, elem_b, last, output ready);
endinterface

interface csu_result_if import csu_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SIM_W-1:0]    similarity;
    logic        [STATUS_W-1:0] status;

    modport source (output valid, similarity, status, input ready);
    modport sink   (input valid, similarity, status, output ready);
endinterface

@@ hdl/csu_seq.sv @@
// ----------------------------------------------------------------------------
// csu_seq
// Microcode sequencer: step counter, iteration counter and the control
// word read from the program table.
// ----------------------------------------------------------------------------
module csu_seq
    import csu_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  flags_t flags,
    output ctrl_t  ctrl
);

    logic [PC_W-1:0]   pc_reg;
    logic [PC_W-1:0]   pc_next;
    logic [ITER_W-1:0] cnt_reg;
    logic [ITER_W-1:0] cnt_next;
    logic              taken;

    assign ctrl = ucode(pc_reg);

    always_comb
    begin
        unique case (ctrl.cond)
            C_ALWAYS:    taken = 1'b1;
            C_LAST:      taken = flags.last_acc;
            C_FAIL:      taken = flags.fail;
            C_ITER_DONE: taken = (cnt_reg == '0);
            C_OUT_FREE:  taken = flags.out_free;
            default:     taken = 1'b0;
        endcase
    end

    always_comb
    begin
        if (taken)
        begin
            pc_next = ctrl.target;
        end
        else if (ctrl.hold)
        begin
            pc_next = pc_reg;
        end
        else
        begin
            pc_next = pc_reg + PC_W'(1);
        end

        cnt_next = cnt_reg;
        if (ctrl.cnt_load)
        begin
            cnt_next = ctrl.cnt_init;
        end
        else if (ctrl.cond == C_ITER_DONE && cnt_reg != '0)
        begin
            cnt_next = cnt_reg - ITER_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= STEP_ACC;
            cnt_reg <= '0;
        end
        else
        begin
            pc_reg  <= pc_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ hdl/cosine_similarity_unit.sv @@
// ----------------------------------------------------------------------------
// cosine_similarity_unit
// Streaming cosine similarity of two vectors, Q1.15 result, driven by a
// small microprogram over a shared shift-and-add datapath.
// ----------------------------------------------------------------------------
// Element pairs arrive on the pairs channel, one transaction per position,
// with last set on the final pair. Each pair is multiplied and accumulated
// in the cycle it is accepted, so a vector streams at one pair per clock.
// After the transaction carrying last, input ready drops while the tail
// runs: a serial shift-and-add multiply of the two norms, a
// two-bits-per-cycle square root and a restoring divide, each after its
// own setup step. The result transaction is offered from the output
// register once the tail is done; when a vector was too long or had a
// zero norm, the tail is skipped and a zero similarity is offered.
// The result sits in an output register: while the receiver stalls, the
// block keeps accepting pairs for the next vector and only waits if that
// vector finishes before the held result is taken.
// Reset clears the accumulators, the pair count and the output valid; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module cosine_similarity_unit
    import csu_pkg::*;
#(
    parameter int MAX_LEN    = 1024,
    parameter int ELEM_WIDTH = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    csu_pair_if.sink        pairs,
    csu_result_if.source    result
);

    localparam int LEN_W = $clog2(MAX_LEN + 1);

    ctrl_t  ctrl;
    flags_t flags;

    // Accumulators and pair count.
    logic [DOT_W-1:0]    dot_reg,  dot_next;
    logic [NORM_W-1:0]   na_reg,   na_next;
    logic [NORM_W-1:0]   nb_reg,   nb_next;
    logic [LEN_W-1:0]    len_reg,  len_next;
    logic                long_reg, long_next;

    // Shared tail datapath. x_reg holds the product, then the radicand,
    // then the dividend with the quotient shifting in at the bottom.
    logic [PROD_W-1:0]   x_reg,    x_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [REM_W-1:0]    rem_reg,  rem_next;
    logic [STATUS_W-1:0] stat_reg, stat_next;

    // Output register.
    logic                out_valid_reg,  out_valid_next;
    logic [SIM_W-1:0]    out_sim_reg,    out_sim_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;

    logic                       accept;
    logic signed [MUL_W-1:0]    a_ext;
    logic signed [MUL_W-1:0]    b_ext;
    logic signed [2*MUL_W-1:0]  p_ab;
    logic signed [2*MUL_W-1:0]  p_aa;
    logic signed [2*MUL_W-1:0]  p_bb;
    logic [NORM_W:0]            mul_sum;
    logic [REM_W-1:0]           sq_rem;
    logic [REM_W-1:0]           sq_trial;
    logic [REM_W-1:0]           dv_rem;
    logic [REM_W-1:0]           dv_div;
    logic [DOT_W-1:0]           dot_mag;
    logic [DIVD_W-1:0]          quo;
    logic [SIM_W-1:0]           q_clamped;
    logic [SIM_W-1:0]           sim_val;
    logic                       dot_neg;

    csu_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    assign pairs.ready       = ctrl.ready;
    assign result.valid      = out_valid_reg;
    assign result.similarity = out_sim_reg;
    assign result.status     = out_status_reg;

    assign accept = pairs.valid && ctrl.ready;

    // Each element is taken from the low ELEM_WIDTH bits of its field and
    // sign-extended to the multiplier width; the accumulators keep only
    // their low bits, so they wrap at their own widths.
    assign a_ext = MUL_W'($signed(pairs.elem_a[ELEM_WIDTH-1:0]));
    assign b_ext = MUL_W'($signed(pairs.elem_b[ELEM_WIDTH-1:0]));
    assign p_ab  = a_ext * b_ext;
    assign p_aa  = a_ext * a_ext;
    assign p_bb  = b_ext * b_ext;

    assign flags.last_acc = accept && pairs.last;
    assign flags.fail     = long_reg || (na_reg == '0) || (nb_reg == '0);
    assign flags.out_free = !out_valid_reg || result.ready;

    // One multiplier step: add the multiplicand into the upper half when the
    // low bit is set, then shift the whole product right.
    assign mul_sum = {1'b0, x_reg[PROD_W-1:NORM_W]}
                   + (x_reg[0] ? {1'b0, na_reg} : '0);

    // One square root step consumes the two top radicand bits.
    assign sq_rem   = {rem_reg[REM_W-3:0], x_reg[PROD_W-1:PROD_W-2]};
    assign sq_trial = REM_W'({root_reg, 2'b01});

    // One restoring divide step by the root.
    assign dv_rem = {rem_reg[REM_W-2:0], x_reg[DIVD_W-1]};
    assign dv_div = REM_W'(root_reg);

    assign dot_neg = dot_reg[DOT_W-1];
    assign dot_mag = dot_neg ? (~dot_reg + DOT_W'(1)) : dot_reg;

    // The quotient is truncated toward zero, then clamped: a negative result
    // may reach -1.0, a positive one stops one LSB short of +1.0.
    assign quo = x_reg[DIVD_W-1:0];
    always_comb
    begin
        if (dot_neg)
        begin
            q_clamped = (quo > DIVD_W'(Q_NEG_MAX)) ? SIM_W'(Q_NEG_MAX)
                                                   : quo[SIM_W-1:0];
            sim_val   = ~q_clamped + SIM_W'(1);
        end
        else
        begin
            q_clamped = (quo > DIVD_W'(Q_POS_MAX)) ? SIM_W'(Q_POS_MAX)
                                                   : quo[SIM_W-1:0];
            sim_val   = q_clamped;
        end
    end

    always_comb
    begin
        dot_next        = dot_reg;
        na_next         = na_reg;
        nb_next         = nb_reg;
        len_next        = len_reg;
        long_next       = long_reg;
        x_next          = x_reg;
        root_next       = root_reg;
        rem_next        = rem_reg;
        stat_next       = stat_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_sim_next    = out_sim_reg;
        out_status_next = out_status_reg;

        unique case (ctrl.op)
            OP_ACC:
            begin
                if (accept)
                begin
                    // Pairs beyond the length limit are dropped and flagged.
                    if (len_reg < LEN_W'(MAX_LEN))
                    begin
                        dot_next = dot_reg + p_ab[DOT_W-1:0];
                        na_next  = na_reg + p_aa[NORM_W-1:0];
                        nb_next  = nb_reg + p_bb[NORM_W-1:0];
                        len_next = len_reg + LEN_W'(1);
                    end
                    else
                    begin
                        long_next = 1'b1;
                    end
                end
            end
            OP_CHK:
            begin
                // Too long takes precedence over a zero norm.
                if (long_reg)
                begin
                    stat_next = ST_TOO_LONG;
                end
                else if (na_reg == '0 || nb_reg == '0)
                begin
                    stat_next = ST_ZERO_NORM;
                end
                else
                begin
                    stat_next = ST_OK;
                end
                x_next = PROD_W'(nb_reg);
            end
            OP_MUL:
            begin
                x_next = {mul_sum, x_reg[NORM_W-1:1]};
            end
            OP_SQI:
            begin
                root_next = '0;
                rem_next  = '0;
            end
            OP_SQ:
            begin
                if (sq_rem >= sq_trial)
                begin
                    rem_next  = sq_rem - sq_trial;
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = sq_rem;
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                x_next = {x_reg[PROD_W-3:0], 2'b00};
            end
            OP_DVI:
            begin
                x_next   = PROD_W'({dot_mag, {FRAC_W{1'b0}}});
                rem_next = '0;
            end
            OP_DV:
            begin
                if (dv_rem >= dv_div)
                begin
                    rem_next = dv_rem - dv_div;
                    x_next   = {x_reg[PROD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = dv_rem;
                    x_next   = {x_reg[PROD_W-2:0], 1'b0};
                end
            end
            OP_OUT:
            begin
                if (flags.out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_sim_next    = (stat_reg == ST_OK) ? sim_val : '0;
                    out_status_next = stat_reg;
                    dot_next        = '0;
                    na_next         = '0;
                    nb_next         = '0;
                    len_next        = '0;
                    long_next       = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg       <= '0;
            na_reg        <= '0;
            nb_reg        <= '0;
            len_reg       <= '0;
            long_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            dot_reg       <= dot_next;
            na_reg        <= na_next;
            nb_reg        <= nb_next;
            len_reg       <= len_next;
            long_reg      <= long_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        root_reg       <= root_next;
        rem_reg        <= rem_next;
        stat_reg       <= stat_next;
        out_sim_reg    <= out_sim_next;
        out_status_reg <= out_status_next;
    end

endmodule

@@ hdl/csu_checker.sv @@
// ----------------------------------------------------------------------------
// csu_checker
// Port-level checks of the cosine similarity unit, bound to the top level.
// ----------------------------------------------------------------------------
module csu_checker
    import csu_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                in_last,
    input logic                out_valid,
    input logic                out_ready,
    input logic [SIM_W-1:0]    similarity,
    input logic [STATUS_W-1:0] status
);

    // Vectors whose last pair was accepted but whose result is not yet taken.
    logic [1:0] pend_reg;
    logic [1:0] pend_next;

    always_comb
    begin
        pend_next = pend_reg;
        if (in_valid && in_ready && in_last)
        begin
            pend_next = pend_next + 2'd1;
        end
        if (out_valid && out_ready)
        begin
            pend_next = pend_next - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(similarity) && $stable(status))
        else $error("result changed while stalled");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> similarity == '0)
        else $error("nonzero similarity with error status");

    a_tail_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !in_ready)
        else $error("pair accepted during result computation");

    a_result_owed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 2'd0)
        else $error("result without a finished vector");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("more than two vectors outstanding");

endmodule

bind cosine_similarity_unit csu_checker u_csu_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (pairs.valid),
    .in_ready   (pairs.ready),
    .in_last    (pairs.last),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .similarity (result.similarity),
    .status     (result.status)
);
